// ===== sv/adof_pkg.sv =====
// ----------------------------------------------------------------------------
// adof_pkg - shared types and codes of the aging drop-oldest fifo
// result kinds, sequencer states, register indexes and configuration bundle
// ----------------------------------------------------------------------------
package adof_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CAP_W      = 6;
  localparam int TMO_W      = 31;
  localparam int SIZE_W     = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 4'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // operation codes of an input transaction
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_EVICT   = 3'd1,
    KIND_EXPIRE  = 3'd2,
    KIND_DELIVER = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_EVICT,
    S_POP,
    S_POP_CHK
  } state_t;

  // effective settings handed from front to back
  typedef struct packed {
    logic [CAP_W-1:0] eff_cap;
    logic [TMO_W-1:0] timeout;
  } cfg_t;

endpackage

// ===== sv/adof_ifs.sv =====
// ----------------------------------------------------------------------------
// adof channel interfaces
// valid/ready channels for input, result and configuration transactions
// ----------------------------------------------------------------------------
interface adof_in_if #(
  parameter int HANDLE_BITS = 32,
  parameter int TIME_BITS   = 48
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [TIME_BITS-1:0]   now_msec;
  logic [HANDLE_BITS-1:0] msg_handle;
  logic [TIME_BITS-1:0]   msg_stamp;

  modport source(output valid, func, now_msec, msg_handle, msg_stamp, input ready);
  modport sink(input valid, func, now_msec, msg_handle, msg_stamp, output ready);
endinterface

interface adof_out_if #(
  parameter int HANDLE_BITS = 32,
  parameter int TIME_BITS   = 48
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             kind;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [TIME_BITS-1:0]   out_stamp;
  logic [TIME_BITS-1:0]   resident_msec;
  logic [5:0]             queue_size;
  logic                   became_nonempty;
  logic                   now_empty;
  logic                   last;

  modport source(output valid, kind, out_handle, out_stamp, resident_msec, queue_size,
                 became_nonempty, now_empty, last, input ready);
  modport sink(input valid, kind, out_handle, out_stamp, resident_msec, queue_size,
               became_nonempty, now_empty, last, output ready);
endinterface

interface adof_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/adof_front.sv =====
// ----------------------------------------------------------------------------
// adof_front - input acceptance, configuration registers, command queue
// accepts transactions into a two-entry queue that feeds the back end
// ----------------------------------------------------------------------------
module adof_front #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  adof_in_if.sink                in_if,
  adof_cfg_if.sink               cfg_if,
  output adof_pkg::cfg_t         cfg,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output logic                   cmd_func,
  output logic [TIME_BITS-1:0]   cmd_now,
  output logic [HANDLE_BITS-1:0] cmd_handle,
  output logic [TIME_BITS-1:0]   cmd_stamp
);
  import adof_pkg::*;

  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

  logic [CAP_W-1:0] cap_r;
  logic [TMO_W-1:0] tmo_r;

  // two-entry command queue
  logic                   q_func_r   [2];
  logic [TIME_BITS-1:0]   q_now_r    [2];
  logic [HANDLE_BITS-1:0] q_handle_r [2];
  logic [TIME_BITS-1:0]   q_stamp_r  [2];
  logic                   wr_ptr_r, rd_ptr_r;
  logic [1:0]             fill_r;
  logic                   push, pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      tmo_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_CAPACITY: cap_r <= cfg_if.data[CAP_W-1:0];
        CFG_TIMEOUT:  tmo_r <= cfg_if.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // zero capacity acts as one, anything above the store depth as the depth
  always_comb begin
    if (cap_r == '0)
      cfg.eff_cap = CAP_W'(1);
    else if (cap_r > DEPTH_C)
      cfg.eff_cap = DEPTH_C;
    else
      cfg.eff_cap = cap_r;
    cfg.timeout = tmo_r;
  end

  assign in_if.ready = (fill_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (fill_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;

  assign cmd_func   = q_func_r[rd_ptr_r];
  assign cmd_now    = q_now_r[rd_ptr_r];
  assign cmd_handle = q_handle_r[rd_ptr_r];
  assign cmd_stamp  = q_stamp_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_func_r[wr_ptr_r]   <= in_if.func;
      q_now_r[wr_ptr_r]    <= in_if.now_msec;
      q_handle_r[wr_ptr_r] <= in_if.msg_handle;
      q_stamp_r[wr_ptr_r]  <= in_if.msg_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== sv/adof_back.sv =====
// ----------------------------------------------------------------------------
// adof_back - entry store sequencer
// runs push / evict / pop / expire over the entry memory, drives the results
// ----------------------------------------------------------------------------
module adof_back #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  adof_pkg::cfg_t         cfg,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic                   cmd_func,
  input  logic [TIME_BITS-1:0]   cmd_now,
  input  logic [HANDLE_BITS-1:0] cmd_handle,
  input  logic [TIME_BITS-1:0]   cmd_stamp,
  adof_out_if.source             out_if
);
  import adof_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(DEPTH - 1);

  state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]   cur_now_r;
  logic [HANDLE_BITS-1:0] cur_handle_r;
  logic [TIME_BITS-1:0]   cur_stamp_r;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  // entry memory, one write and one registered read a cycle
  logic [HANDLE_BITS-1:0] mem_handle [DEPTH];
  logic [TIME_BITS-1:0]   mem_stamp  [DEPTH];
  logic [TIME_BITS-1:0]   mem_etime  [DEPTH];
  logic [HANDLE_BITS-1:0] rd_handle_r;
  logic [TIME_BITS-1:0]   rd_stamp_r;
  logic [TIME_BITS-1:0]   rd_etime_r;
  logic                   mem_rd, mem_wr;
  logic [CNT_W:0]         tail_sum;
  logic [IDX_W-1:0]       tail;

  // result register
  logic                   ov_r;
  kind_t                  o_kind_r;
  logic [HANDLE_BITS-1:0] o_handle_r;
  logic [TIME_BITS-1:0]   o_stamp_r;
  logic [TIME_BITS-1:0]   o_res_r;
  logic [SIZE_W-1:0]      o_size_r;
  logic                   o_ne_r, o_empty_r, o_last_r;

  logic                   emit;
  kind_t                  e_kind;
  logic [HANDLE_BITS-1:0] e_handle;
  logic [TIME_BITS-1:0]   e_stamp;
  logic [TIME_BITS-1:0]   e_res;
  logic [SIZE_W-1:0]      e_size;
  logic                   e_ne, e_empty, e_last;

  logic                   slot_free, full, aged;
  logic [TIME_BITS:0]     age_diff, res_diff;
  logic [TIME_BITS-1:0]   resident;
  logic [IDX_W-1:0]       head_inc;

  assign slot_free = !ov_r || out_if.ready;
  assign full      = (SIZE_W'(cnt_r) >= cfg.eff_cap);
  assign head_inc  = (head_r == LAST_IX) ? '0 : head_r + 1'b1;

  assign tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(cnt_r);
  assign tail     = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);

  // age of the head entry against the header stamp, resident time against entry time
  assign age_diff = {1'b0, cur_now_r} - {1'b0, rd_stamp_r};
  assign res_diff = {1'b0, cur_now_r} - {1'b0, rd_etime_r};
  assign resident = res_diff[TIME_BITS] ? '0 : res_diff[TIME_BITS-1:0];
  assign aged     = (cfg.timeout != '0) && (rd_stamp_r != '0) && !age_diff[TIME_BITS] &&
                    (age_diff[TIME_BITS-1:0] > TIME_BITS'(cfg.timeout));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) state_nxt = (cmd_func == FUNC_POP) ? S_POP : S_PUSH;
      end
      S_PUSH: begin
        if (full) state_nxt = S_EVICT;
        else if (slot_free) state_nxt = S_IDLE;
      end
      S_EVICT: begin
        if (slot_free) state_nxt = S_PUSH;
      end
      S_POP: begin
        if (cnt_r != '0) state_nxt = S_POP_CHK;
        else if (slot_free) state_nxt = S_IDLE;
      end
      S_POP_CHK: begin
        if (slot_free) state_nxt = aged ? S_POP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    emit      = 1'b0;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    e_kind    = KIND_PUSH;
    e_handle  = rd_handle_r;
    e_stamp   = rd_stamp_r;
    e_res     = resident;
    e_size    = SIZE_W'(cnt_r - 1'b1);
    e_ne      = 1'b0;
    e_empty   = 1'b0;
    e_last    = 1'b0;
    case (state_r)
      S_IDLE: cmd_ready = 1'b1;
      S_PUSH: begin
        if (full) begin
          mem_rd = 1'b1;
        end else if (slot_free) begin
          mem_wr   = 1'b1;
          emit     = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          e_kind   = KIND_PUSH;
          e_handle = cur_handle_r;
          e_stamp  = cur_stamp_r;
          e_res    = '0;
          e_size   = SIZE_W'(cnt_r + 1'b1);
          e_ne     = (cnt_r == '0);
          e_last   = 1'b1;
        end
      end
      S_EVICT: begin
        if (slot_free) begin
          emit     = 1'b1;
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
          e_kind   = KIND_EVICT;
        end
      end
      S_POP: begin
        if (cnt_r != '0) begin
          mem_rd = 1'b1;
        end else if (slot_free) begin
          emit     = 1'b1;
          e_kind   = KIND_EMPTY;
          e_handle = '0;
          e_stamp  = '0;
          e_res    = '0;
          e_size   = '0;
          e_empty  = 1'b1;
          e_last   = 1'b1;
        end
      end
      S_POP_CHK: begin
        if (slot_free) begin
          emit     = 1'b1;
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
          if (aged) begin
            e_kind = KIND_EXPIRE;
          end else begin
            e_kind  = KIND_DELIVER;
            e_empty = (cnt_r == CNT_W'(1));
            e_last  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_if.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur_now_r    <= cmd_now;
      cur_handle_r <= cmd_handle;
      cur_stamp_r  <= cmd_stamp;
    end
    if (emit) begin
      o_kind_r   <= e_kind;
      o_handle_r <= e_handle;
      o_stamp_r  <= e_stamp;
      o_res_r    <= e_res;
      o_size_r   <= e_size;
      o_ne_r     <= e_ne;
      o_empty_r  <= e_empty;
      o_last_r   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem_handle[tail] <= cur_handle_r;
      mem_stamp[tail]  <= cur_stamp_r;
      mem_etime[tail]  <= cur_now_r;
    end
    if (mem_rd) begin
      rd_handle_r <= mem_handle[head_r];
      rd_stamp_r  <= mem_stamp[head_r];
      rd_etime_r  <= mem_etime[head_r];
    end
  end

  assign out_if.valid           = ov_r;
  assign out_if.kind            = o_kind_r;
  assign out_if.out_handle      = o_handle_r;
  assign out_if.out_stamp       = o_stamp_r;
  assign out_if.resident_msec   = o_res_r;
  assign out_if.queue_size      = o_size_r;
  assign out_if.became_nonempty = o_ne_r;
  assign out_if.now_empty       = o_empty_r;
  assign out_if.last            = o_last_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!ov_r || out_if.ready))
    else $error("result register overwritten while held");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_last) |=> (state_r == S_IDLE))
    else $error("sequencer not idle after final result");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_kind == KIND_EMPTY) |-> (cnt_r == '0))
    else $error("empty result with entries held");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr))
    else $error("memory read and write in one cycle");
`endif

endmodule

// ===== sv/aging_drop_oldest_fifo_core.sv =====
// ----------------------------------------------------------------------------
// aging_drop_oldest_fifo_core - bounded handle fifo with overflow eviction and age expiry
// pushes evict the oldest entries when full, pops skip aged-out entries
// ----------------------------------------------------------------------------
// A push runs the sequencer's push state, with an evict state and the push state
// again for each entry evicted on overflow; a pop runs the pop and pop-check
// states, again for each expired entry skipped, and an empty pop the pop state
// only. The states follow the single read port of the entry memory, whose
// registered read data must be back before an entry can be judged and reported.
// A two-entry command queue lets new transactions be taken while the sequencer
// works, and a result register lets the sequencer go on while the previous result
// waits. There is no clearing pass: entries are only read after they were written.
module aging_drop_oldest_fifo_core #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  adof_in_if.sink    in_if,
  adof_out_if.source out_if,
  adof_cfg_if.sink   cfg_if
);
  import adof_pkg::*;

  // effective capacity and timeout; the user holds them stable while idle, not enforced
  cfg_t                   cfg;

  // front to back command handoff
  logic                   cmd_valid;
  logic                   cmd_ready;
  logic                   cmd_func;
  logic [TIME_BITS-1:0]   cmd_now;
  logic [HANDLE_BITS-1:0] cmd_handle;
  logic [TIME_BITS-1:0]   cmd_stamp;

  // front: accepts input transactions, holds the configuration registers
  adof_front #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_func   (cmd_func),
    .cmd_now    (cmd_now),
    .cmd_handle (cmd_handle),
    .cmd_stamp  (cmd_stamp)
  );

  // back: entry memory, head/count and the push / pop sequencer
  adof_back #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_func   (cmd_func),
    .cmd_now    (cmd_now),
    .cmd_handle (cmd_handle),
    .cmd_stamp  (cmd_stamp),
    .out_if     (out_if)
  );

endmodule
